FILE: rtl/core/scaled_matrix_multiply_accumulate_defines.svh
// Assertion macros shared by the matrix multiply-accumulate RTL.
`ifndef SCALED_MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define SCALED_MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define SMMA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Asserts that an antecedent implies a consequent in the following cycle.
`define SMMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/core/smma_pkg.sv
// Package with types, constants and helpers for the matrix multiply-accumulate.
package smma_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_BITS = $clog2(MAX_DIM);
  localparam int ADDR_BITS = 2 * IDX_BITS;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int OPERAND_BITS = 16;
  localparam int RESULT_BITS = 32;
  localparam int DIM_BITS = 4;
  localparam int SUM_BITS = 2 * OPERAND_BITS + IDX_BITS + 1;
  localparam int TOTAL_BITS = 64;

  localparam logic [2:0] ACT_LOAD_FIRST = 3'd0;
  localparam logic [2:0] ACT_LOAD_SECOND = 3'd1;
  localparam logic [2:0] ACT_LOAD_RESULT = 3'd2;
  localparam logic [2:0] ACT_COMPUTE = 3'd3;
  localparam logic [2:0] ACT_READ = 3'd4;

  localparam logic [2:0] REG_TRANSPOSE_FIRST = 3'd0;
  localparam logic [2:0] REG_TRANSPOSE_SECOND = 3'd1;
  localparam logic [2:0] REG_RESULT_ROWS = 3'd2;
  localparam logic [2:0] REG_RESULT_COLS = 3'd3;
  localparam logic [2:0] REG_INNER_LENGTH = 3'd4;
  localparam logic [2:0] REG_PRODUCT_SCALE = 3'd5;
  localparam logic [2:0] REG_ACCUMULATE_SCALE = 3'd6;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] elem_row;
    logic [2:0] elem_col;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_row;
    logic [2:0] out_col;
    logic signed [31:0] out_value;
  } out_item_t;

  typedef struct packed {
    logic transpose_first;
    logic transpose_second;
    logic [DIM_BITS-1:0] result_rows;
    logic [DIM_BITS-1:0] result_cols;
    logic [DIM_BITS-1:0] inner_length;
    logic signed [15:0] product_scale;
    logic signed [15:0] accumulate_scale;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_sum;    // start a new element sum
    logic mac_en;       // add the product of the operands read last cycle
    logic rd_en;        // read operands at row, col, k
    logic scale_en;     // take the finished sum into the scaling stage
    logic final_en;     // combine the scaled terms and write C
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic [IDX_BITS-1:0] k;
  } dp_cmd_t;

  // Saturates a wide signed value to the Q8.8 operand range.
  function automatic logic [OPERAND_BITS-1:0] sat_operand(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd32767;
    lo = -32'sd32768;
    if (v > hi) return OPERAND_BITS'(hi);
    else if (v < lo) return OPERAND_BITS'(lo);
    else return v[OPERAND_BITS-1:0];
  endfunction

  // Clamps a dimension to the largest array size.
  function automatic logic [DIM_BITS-1:0] limit_dim(input logic [DIM_BITS-1:0] d);
    if (d > DIM_BITS'(MAX_DIM)) return DIM_BITS'(MAX_DIM);
    else return d;
  endfunction

endpackage

FILE: rtl/core/smma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module smma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/smma_datapath.sv
// Datapath: operand and result stores, multiply-accumulate and scaling stages.
module smma_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  smma_pkg::cfg_t       cfg,
  input  smma_pkg::dp_cmd_t    cmd,
  input  logic                 load_first,
  input  logic                 load_second,
  input  logic                 load_result,
  input  logic                 read_req,
  input  smma_pkg::in_item_t   item,
  output smma_pkg::out_item_t  result,
  output logic                 result_valid
);
  import smma_pkg::*;

  logic [ADDR_BITS-1:0] item_addr;
  logic [ADDR_BITS-1:0] a_addr;
  logic [ADDR_BITS-1:0] b_addr;
  logic [ADDR_BITS-1:0] c_raddr;
  logic [ADDR_BITS-1:0] c_waddr;
  logic [OPERAND_BITS-1:0] a_rd;
  logic [OPERAND_BITS-1:0] b_rd;
  logic [RESULT_BITS-1:0] c_rd;
  logic [RESULT_BITS-1:0] c_wdata;
  logic c_we;
  logic [DEPTH-1:0] c_valid;
  logic c_rd_valid;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [2*OPERAND_BITS-1:0] prod;
  logic signed [TOTAL_BITS-1:0] alpha_term;
  logic signed [TOTAL_BITS-1:0] beta_term;
  logic signed [TOTAL_BITS-1:0] total;
  logic signed [TOTAL_BITS-1:0] shifted;
  logic [ADDR_BITS-1:0] pend_addr;
  logic [ADDR_BITS-1:0] scale_addr;
  logic read_pend;
  logic read_inside;
  logic [2:0] read_row;
  logic [2:0] read_col;
  logic [RESULT_BITS-1:0] c_eff;

  // Saturates the shifted total to the result range.
  function automatic logic [RESULT_BITS-1:0] shifted_sat(input logic signed [TOTAL_BITS-1:0] v);
    if (v > TOTAL_BITS'(64'sh7FFF_FFFF)) return RESULT_BITS'(32'h7FFF_FFFF);
    else if (v < -TOTAL_BITS'(64'sh8000_0000)) return RESULT_BITS'(32'h8000_0000);
    else return v[RESULT_BITS-1:0];
  endfunction

  assign item_addr = {item.elem_row[IDX_BITS-1:0], item.elem_col[IDX_BITS-1:0]};
  assign a_addr = cfg.transpose_first ? {cmd.k, cmd.row} : {cmd.row, cmd.k};
  assign b_addr = cfg.transpose_second ? {cmd.col, cmd.k} : {cmd.k, cmd.col};
  assign c_raddr = read_req ? item_addr : {cmd.row, cmd.col};

  // Operand stores.
  smma_ram #(.WIDTH(OPERAND_BITS), .DEPTH(DEPTH)) u_first (
    .clk(clk), .we(load_first), .waddr(item_addr),
    .wdata(sat_operand(item.elem_value)), .raddr(a_addr), .rdata(a_rd));
  smma_ram #(.WIDTH(OPERAND_BITS), .DEPTH(DEPTH)) u_second (
    .clk(clk), .we(load_second), .waddr(item_addr),
    .wdata(sat_operand(item.elem_value)), .raddr(b_addr), .rdata(b_rd));

  // Result store; entries never written read as zero through valid bits.
  assign c_we = load_result || cmd.final_en;
  assign c_waddr = load_result ? item_addr : scale_addr;
  assign c_wdata = load_result ? item.elem_value : shifted_sat(shifted);
  smma_ram #(.WIDTH(RESULT_BITS), .DEPTH(DEPTH)) u_result (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rd));
  assign c_eff = c_rd_valid ? c_rd : '0;

  // Product of the operands read in the previous cycle.
  assign prod = $signed(a_rd) * $signed(b_rd);
  assign total = alpha_term + beta_term;
  assign shifted = total >>> 8;

  // Valid bits, sum, scaling stage and read return.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= '0;
      read_pend <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (c_we) c_valid[c_waddr] <= 1'b1;
      read_pend <= read_req;
      result_valid <= read_pend;
    end
    c_rd_valid <= c_valid[c_raddr];
    pend_addr <= {cmd.row, cmd.col};
    if (cmd.clear_sum) sum <= '0;
    else if (cmd.mac_en) sum <= sum + SUM_BITS'(prod);
    if (cmd.scale_en) begin
      alpha_term <= TOTAL_BITS'(sum) * TOTAL_BITS'(cfg.product_scale);
      beta_term <= (cfg.accumulate_scale == '0) ? '0 :
                   TOTAL_BITS'($signed(c_eff)) * TOTAL_BITS'(cfg.accumulate_scale);
      scale_addr <= pend_addr;
    end
    if (read_req) begin
      read_row <= item.elem_row;
      read_col <= item.elem_col;
      read_inside <= 1'b1;
    end
    if (read_pend) begin
      result.out_row <= read_row;
      result.out_col <= read_col;
      result.out_value <= read_inside ? c_eff : '0;
    end
  end
endmodule

FILE: rtl/core/smma_controller.sv
// Controller: decodes items and sequences the multiply-accumulate loops.
module smma_controller (
  input  logic                clk,
  input  logic                rst,
  input  smma_pkg::cfg_t      cfg,
  input  logic                start,
  input  smma_pkg::in_item_t  item,
  output logic                busy,
  output smma_pkg::dp_cmd_t   cmd,
  output logic                load_first,
  output logic                load_second,
  output logic                load_result,
  output logic                read_req
);
  import smma_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_SCALE, S_WRITE, S_READ} state_t;

  state_t state;
  logic [DIM_BITS-1:0] rows;
  logic [DIM_BITS-1:0] cols;
  logic [DIM_BITS-1:0] inner;
  logic [DIM_BITS-1:0] r;
  logic [DIM_BITS-1:0] c;
  logic [DIM_BITS-1:0] k;
  logic accept;

  assign accept = start && !busy;
  assign load_first = accept && item.action == ACT_LOAD_FIRST;
  assign load_second = accept && item.action == ACT_LOAD_SECOND;
  assign load_result = accept && item.action == ACT_LOAD_RESULT;
  assign read_req = accept && item.action == ACT_READ;
  assign busy = state != S_IDLE;

  // Command decode from the state and loop counters.
  always_comb begin
    cmd = '0;
    cmd.row = r[IDX_BITS-1:0];
    cmd.col = c[IDX_BITS-1:0];
    cmd.k = k[IDX_BITS-1:0];
    unique case (state)
      S_IDLE: cmd.clear_sum = 1'b1;
      S_MAC: begin
        cmd.rd_en = k < inner;
        cmd.mac_en = k != '0;
      end
      S_DRAIN: cmd.mac_en = inner != '0;
      S_SCALE: cmd.scale_en = 1'b1;
      S_WRITE: begin
        cmd.final_en = 1'b1;
        cmd.clear_sum = 1'b1;
      end
      S_READ: ;
      default: ;
    endcase
  end

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r <= '0;
      c <= '0;
      k <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rows <= limit_dim(cfg.result_rows);
          cols <= limit_dim(cfg.result_cols);
          inner <= limit_dim(cfg.inner_length);
          r <= '0;
          c <= '0;
          k <= '0;
          if (accept && item.action == ACT_COMPUTE &&
              cfg.result_rows != '0 && cfg.result_cols != '0) state <= S_MAC;
          else if (read_req) state <= S_READ;
        end
        S_MAC: begin
          if (k + 1'b1 >= inner || inner == '0) state <= S_DRAIN;
          else k <= k + 1'b1;
        end
        // Last product arrives; the C read address is still r,c here.
        S_DRAIN: state <= S_SCALE;
        S_SCALE: state <= S_WRITE;
        S_WRITE: begin
          k <= '0;
          if (c + 1'b1 < cols) begin
            c <= c + 1'b1;
            state <= S_MAC;
          end else if (r + 1'b1 < rows) begin
            c <= '0;
            r <= r + 1'b1;
            state <= S_MAC;
          end else state <= S_IDLE;
        end
        S_READ: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/scaled_matrix_multiply_accumulate.sv
// Top level of the scaled matrix multiply-accumulate with its register port.
//  channel | direction | handshake
//  item    | in        | start high while busy low
//  result  | out       | done strobe, one cycle, cannot be held off
//  config  | in        | APB write, pready always high
// Loads leave busy low. A read raises busy in S_READ, and its done strobe
// follows the accepted item through the read_pend and result_valid registers.
// A compute keeps busy high while each element of C in turn passes S_MAC,
// S_DRAIN, S_SCALE and S_WRITE on the single shared multiply-accumulate unit;
// with zero rows or columns it completes at once. Reset is synchronous; the
// result store reads as zero until written, tracked by one valid bit per entry.
module scaled_matrix_multiply_accumulate (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  smma_pkg::in_item_t   item,
  output logic                 busy,
  output logic                 done,
  output smma_pkg::out_item_t  result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import smma_pkg::*;
  `include "scaled_matrix_multiply_accumulate_defines.svh"

  cfg_t cfg;
  dp_cmd_t cmd;
  logic load_first;
  logic load_second;
  logic load_result;
  logic read_req;
  logic wr;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transpose_first <= 1'b0;
      cfg.transpose_second <= 1'b0;
      cfg.result_rows <= DIM_BITS'(MAX_DIM);
      cfg.result_cols <= DIM_BITS'(MAX_DIM);
      cfg.inner_length <= DIM_BITS'(MAX_DIM);
      cfg.product_scale <= 16'sd256;
      cfg.accumulate_scale <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_TRANSPOSE_FIRST: cfg.transpose_first <= pwdata[0];
        REG_TRANSPOSE_SECOND: cfg.transpose_second <= pwdata[0];
        REG_RESULT_ROWS: cfg.result_rows <= pwdata[3:0];
        REG_RESULT_COLS: cfg.result_cols <= pwdata[3:0];
        REG_INNER_LENGTH: cfg.inner_length <= pwdata[3:0];
        REG_PRODUCT_SCALE: cfg.product_scale <= pwdata[15:0];
        REG_ACCUMULATE_SCALE: cfg.accumulate_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TRANSPOSE_FIRST: prdata[0] = cfg.transpose_first;
      REG_TRANSPOSE_SECOND: prdata[0] = cfg.transpose_second;
      REG_RESULT_ROWS: prdata[3:0] = cfg.result_rows;
      REG_RESULT_COLS: prdata[3:0] = cfg.result_cols;
      REG_INNER_LENGTH: prdata[3:0] = cfg.inner_length;
      REG_PRODUCT_SCALE: prdata = 32'($signed(cfg.product_scale));
      REG_ACCUMULATE_SCALE: prdata = 32'($signed(cfg.accumulate_scale));
      default: ;
    endcase
  end

  smma_controller u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start), .item(item), .busy(busy),
    .cmd(cmd), .load_first(load_first), .load_second(load_second),
    .load_result(load_result), .read_req(read_req));

  smma_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .load_first(load_first),
    .load_second(load_second), .load_result(load_result), .read_req(read_req),
    .item(item), .result(result), .result_valid(done));

  // The controller stays busy in the cycle after a read transaction.
  `SMMA_ASSERT_NEXT(a_read_busy, read_req, busy)
  // Loads only happen when the controller is idle.
  `SMMA_ASSERT_IMPL(a_load_idle, load_first || load_second || load_result, !busy)
  // A result strobe follows an accepted read transaction through two registers.
  `SMMA_ASSERT_IMPL(a_done_after_read, done, $past(read_req, 2))
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the scaled matrix multiply-accumulate block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smma_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t item = '0;
  logic busy;
  logic done;
  out_item_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  scaled_matrix_multiply_accumulate u_dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block's configuration and stores.
  logic tr_first, tr_second;
  logic [3:0] rows_reg, cols_reg, inner_reg;
  logic signed [15:0] alpha, beta;
  logic signed [15:0] mat_a [8][8];
  logic signed [15:0] mat_b [8][8];
  logic signed [31:0] mat_c [8][8];
  bit a_written [8][8];
  bit b_written [8][8];

  out_item_t pending_reads [$];
  int mismatches = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int computes_sent = 0;
  int config_writes = 0;
  int cycles = 0;
  bit start_high = 1'b0;

  // Prints one line per mismatch and keeps count.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  function automatic longint clamp_to(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic int eff_dim(input logic [3:0] d);
    return (d > 4'd8) ? 8 : int'(d);
  endfunction

  // Recomputes the used region of C as the block does.
  function automatic void update_result_matrix();
    longint sum, total;
    longint a, b;
    for (int r = 0; r < eff_dim(rows_reg); r++) begin
      for (int c = 0; c < eff_dim(cols_reg); c++) begin
        sum = 0;
        for (int k = 0; k < eff_dim(inner_reg); k++) begin
          a = tr_first ? mat_a[k][r] : mat_a[r][k];
          b = tr_second ? mat_b[c][k] : mat_b[k][c];
          sum += a * b;
        end
        total = longint'(alpha) * sum;
        if (beta != 0) total += longint'(beta) * longint'(mat_c[r][c]);
        total = total >>> 8;
        mat_c[r][c] = 32'(clamp_to(total, 32));
      end
    end
  endfunction

  // Applies one accepted transaction to the shadow state.
  function automatic void apply_item(input in_item_t it);
    out_item_t exp_out;
    case (it.action)
      ACT_LOAD_FIRST: begin
        mat_a[it.elem_row][it.elem_col] = 16'(clamp_to(longint'(it.elem_value), 16));
        a_written[it.elem_row][it.elem_col] = 1'b1;
      end
      ACT_LOAD_SECOND: begin
        mat_b[it.elem_row][it.elem_col] = 16'(clamp_to(longint'(it.elem_value), 16));
        b_written[it.elem_row][it.elem_col] = 1'b1;
      end
      ACT_LOAD_RESULT: mat_c[it.elem_row][it.elem_col] = it.elem_value;
      ACT_COMPUTE: update_result_matrix();
      ACT_READ: begin
        exp_out.out_row = it.elem_row;
        exp_out.out_col = it.elem_col;
        exp_out.out_value = mat_c[it.elem_row][it.elem_col];
        pending_reads.push_back(exp_out);
      end
      default: ;
    endcase
  endfunction

  // Drives one transaction and holds it until the block takes it.
  task automatic send_item(input logic [2:0] act, input logic [2:0] r, input logic [2:0] c,
                           input logic signed [31:0] v);
    in_item_t it;
    it.action = act;
    it.elem_row = r;
    it.elem_col = c;
    it.elem_value = v;
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    start_high = 1'b1;
    while (busy) @(negedge clk);
    apply_item(it);
    items_sent++;
    if (act == ACT_COMPUTE) computes_sent++;
    @(posedge clk);
  endtask

  // Lowers start at the next falling edge if it is still raised.
  task automatic release_start();
    if (start_high) begin
      @(negedge clk);
      start <= 1'b0;
      start_high = 1'b0;
    end
  endtask

  task automatic idle_gap(input int n);
    release_start();
    repeat (n) @(negedge clk);
  endtask

  // Waits until every read has returned and the block has gone idle.
  task automatic wait_quiet();
    release_start();
    while (pending_reads.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write over the APB port: a setup phase then an access phase.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_quiet();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    config_writes++;
    case (idx)
      REG_TRANSPOSE_FIRST: tr_first = val[0];
      REG_TRANSPOSE_SECOND: tr_second = val[0];
      REG_RESULT_ROWS: rows_reg = val[3:0];
      REG_RESULT_COLS: cols_reg = val[3:0];
      REG_INNER_LENGTH: inner_reg = val[3:0];
      REG_PRODUCT_SCALE: alpha = val[15:0];
      REG_ACCUMULATE_SCALE: beta = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input bit ta, input bit tb, input logic [3:0] r, input logic [3:0] c,
                           input logic [3:0] k, input logic [15:0] al, input logic [15:0] be);
    write_reg(REG_TRANSPOSE_FIRST, 32'(ta));
    write_reg(REG_TRANSPOSE_SECOND, 32'(tb));
    write_reg(REG_RESULT_ROWS, 32'(r));
    write_reg(REG_RESULT_COLS, 32'(c));
    write_reg(REG_INNER_LENGTH, 32'(k));
    write_reg(REG_PRODUCT_SCALE, {16'h0, al});
    write_reg(REG_ACCUMULATE_SCALE, {16'h0, be});
  endtask

  // Random element value: mostly Q8.8 range, some far outside it.
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 1) ? 32767 : -32768);
      2: return 32'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      default: return 32'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  // Loads any operand entry that the next compute would read before it is written.
  task automatic fill_operands();
    int ra, ca;
    for (int r = 0; r < eff_dim(rows_reg); r++) begin
      for (int k = 0; k < eff_dim(inner_reg); k++) begin
        ra = tr_first ? k : r;
        ca = tr_first ? r : k;
        if (!a_written[ra][ca]) send_item(ACT_LOAD_FIRST, 3'(ra), 3'(ca), random_value());
      end
    end
    for (int c = 0; c < eff_dim(cols_reg); c++) begin
      for (int k = 0; k < eff_dim(inner_reg); k++) begin
        ra = tr_second ? c : k;
        ca = tr_second ? k : c;
        if (!b_written[ra][ca]) send_item(ACT_LOAD_SECOND, 3'(ra), 3'(ca), random_value());
      end
    end
  endtask

  task automatic compute_now();
    fill_operands();
    send_item(ACT_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom());
  endtask

  // Check each read result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        report_mismatch("unexpected result", longint'(result.out_value), 0);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (result.out_row != want.out_row)
          report_mismatch("out_row", result.out_row, want.out_row);
        if (result.out_col != want.out_col)
          report_mismatch("out_col", result.out_col, want.out_col);
        if (result.out_value != want.out_value)
          report_mismatch("out_value", result.out_value, want.out_value);
      end
    end
  end

  // Cycle limit against a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Extremes of the fields, all actions and the special cases on a small shape.
  task automatic test_directed();
    set_shape(1'b0, 1'b0, 4'd2, 4'd3, 4'd2, 16'sd256, 16'sd0);
    send_item(ACT_READ, 3'd7, 3'd7, 32'h0);
    send_item(ACT_LOAD_FIRST, 3'd0, 3'd0, 32'h7fffffff);
    send_item(ACT_LOAD_FIRST, 3'd0, 3'd1, 32'h80000000);
    send_item(ACT_LOAD_FIRST, 3'd1, 3'd0, 32'sd32767);
    send_item(ACT_LOAD_FIRST, 3'd1, 3'd1, -32'sd32768);
    send_item(ACT_LOAD_SECOND, 3'd0, 3'd0, 32'sd32767);
    send_item(ACT_LOAD_SECOND, 3'd1, 3'd0, 32'sd32767);
    send_item(ACT_LOAD_SECOND, 3'd0, 3'd1, -32'sd256);
    send_item(ACT_LOAD_SECOND, 3'd1, 3'd1, 32'sd384);
    send_item(ACT_LOAD_SECOND, 3'd0, 3'd2, 32'sd1);
    send_item(ACT_LOAD_SECOND, 3'd1, 3'd2, -32'sd1);
    send_item(ACT_LOAD_RESULT, 3'd7, 3'd7, 32'h80000000);
    send_item(ACT_LOAD_RESULT, 3'd0, 3'd0, 32'h7fffffff);
    send_item(3'd5, 3'd7, 3'd7, 32'hffffffff);
    send_item(3'd7, 3'd0, 3'd0, 32'h0);
    send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
    for (int c = 0; c < 3; c++) send_item(ACT_READ, 3'd1, 3'(c), 32'h0);
    send_item(ACT_READ, 3'd0, 3'd0, 32'h0);
    send_item(ACT_READ, 3'd7, 3'd7, 32'h0);
    send_item(3'd6, 3'd1, 3'd1, 32'h12345678);
    write_reg(REG_ACCUMULATE_SCALE, 32'h0000ff80);
    send_item(ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
    send_item(ACT_READ, 3'd0, 3'd0, 32'h0);
    send_item(ACT_READ, 3'd0, 3'd2, 32'h0);
  endtask

  // Register extremes: zero sizes, oversized sizes, both transposes, extreme scales.
  task automatic test_config_extremes();
    set_shape(1'b1, 1'b1, 4'd0, 4'd5, 4'd3, 16'h8000, 16'h7fff);
    compute_now();
    send_item(ACT_READ, 3'd0, 3'd0, 32'h0);
    set_shape(1'b1, 1'b0, 4'd3, 4'd2, 4'd0, 16'h7fff, 16'h8000);
    compute_now();
    for (int r = 0; r < 3; r++) send_item(ACT_READ, 3'(r), 3'd1, 32'h0);
    set_shape(1'b0, 1'b1, 4'd15, 4'd15, 4'd15, 16'h8000, 16'h8000);
    compute_now();
    for (int i = 0; i < 8; i++) send_item(ACT_READ, 3'(i), 3'(7 - i), 32'h0);
    set_shape(1'b1, 1'b1, 4'd9, 4'd1, 4'd8, 16'h0001, 16'h0000);
    compute_now();
    send_item(ACT_READ, 3'd7, 3'd0, 32'h0);
  endtask

  // Phases of random traffic, each under a fresh random configuration.
  task automatic test_random_traffic();
    int burst;
    logic [2:0] act;
    logic [3:0] dims [3];
    for (int phase = 0; phase < 10; phase++) begin
      foreach (dims[i])
        dims[i] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 4));
      set_shape(1'($urandom()), 1'($urandom()), dims[0], dims[1], dims[2],
                16'($urandom()), ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom()));
      for (int n = 0; n < 60; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: act = ACT_LOAD_FIRST;
            5, 6, 7, 8: act = ACT_LOAD_SECOND;
            9, 10: act = ACT_LOAD_RESULT;
            11: act = ACT_COMPUTE;
            12: act = 3'($urandom_range(5, 7));
            default: act = ACT_READ;
          endcase
          if (act == ACT_COMPUTE) compute_now();
          else send_item(act, 3'($urandom()), 3'($urandom()), random_value());
          if (act <= ACT_READ) n++;
        end
        // Long stretches in even phases run without gaps.
        if (phase % 2 == 1 || $urandom_range(0, 3) == 0) idle_gap($urandom_range(0, 5));
        if ($urandom_range(0, 29) == 0) wait_quiet();
      end
    end
  endtask

  initial begin
    tr_first = 1'b0;
    tr_second = 1'b0;
    rows_reg = 4'd8;
    cols_reg = 4'd8;
    inner_reg = 4'd8;
    alpha = 16'sd256;
    beta = 16'sd0;
    foreach (mat_c[r, c]) begin
      mat_c[r][c] = '0;
      mat_a[r][c] = '0;
      mat_b[r][c] = '0;
      a_written[r][c] = 1'b0;
      b_written[r][c] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random_traffic();
    wait_quiet();
    repeat (20) @(negedge clk);
    $display("Sent %0d items including %0d computes; %0d read results checked.",
             items_sent, computes_sent, reads_checked);
    $display("%0d register writes covered zero, full and oversized shapes and both transposes.",
             config_writes);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: scaled_matrix_multiply_accumulate.f
+incdir+rtl/core
rtl/core/smma_pkg.sv
rtl/core/smma_ram.sv
rtl/core/smma_datapath.sv
rtl/core/smma_controller.sv
rtl/core/scaled_matrix_multiply_accumulate.sv
tb/sv/testbench.sv
